FILE: rtl/kmcs_pkg.sv
// Shared constants, types and the key map expansion for the key matrix column scanner.
package kmcs_pkg;

  localparam int COLUMNS   = 4;
  localparam int ROWS      = 4;
  localparam int COL_W     = $clog2(COLUMNS);
  localparam int PEND_W    = $clog2(COLUMNS + 1);
  localparam int KEY_MAP_W = 17;
  localparam int ENTER_BIT = 16;
  localparam int IDLE_W    = 8;

  localparam logic [IDLE_W-1:0] IDLE_RESCAN_RESET = 8'd25;

  typedef logic [COLUMNS-1:0][ROWS-1:0] col_keys_t;
  typedef logic [4:0] key_bit_t;
  typedef key_bit_t [COLUMNS-1:0][ROWS-1:0] key_table_t;

  // Key map bit position for each (column, row) switch.
  localparam key_table_t KEY_BIT_OF = '{
    '{5'd15, 5'd14, 5'd13, 5'd12},
    '{5'd11, 5'd10, 5'd8,  5'd9},
    '{5'd7,  5'd6,  5'd1,  5'd0},
    '{5'd4,  5'd5,  5'd2,  5'd3}
  };

  // Spreads the cached per-column keys over the key map and adds the enter key.
  function automatic logic [KEY_MAP_W-1:0] expand_keys(input col_keys_t keys,
                                                        input logic enter_pin);
    logic [KEY_MAP_W-1:0] map;
    map = '0;
    for (int c = 0; c < COLUMNS; c++) begin
      for (int r = 0; r < ROWS; r++) begin
        if (keys[c][r]) begin
          map[KEY_BIT_OF[c][r]] = 1'b1;
        end
      end
    end
    map[ENTER_BIT] = ~enter_pin;
    return map;
  endfunction

endpackage

FILE: rtl/kmcs_in_if.sv
// Request channel into the scanner: one poll tick with the sampled pin levels.
interface kmcs_in_if;
  logic                       valid;
  logic                       ready;
  logic [kmcs_pkg::ROWS-1:0]  row_lines;
  logic                       enter_pin;
  logic                       change_request;
  logic                       suspend;

  modport source (output valid, row_lines, enter_pin, change_request, suspend,
                  input ready);
  modport sink (input valid, row_lines, enter_pin, change_request, suspend,
                output ready);
endinterface

FILE: rtl/kmcs_out_if.sv
// Result channel out of the scanner: key map and column drive levels per tick.
interface kmcs_out_if;
  logic                            valid;
  logic                            ready;
  logic [kmcs_pkg::KEY_MAP_W-1:0]  key_map;
  logic [kmcs_pkg::COLUMNS-1:0]    column_drive;

  modport source (output valid, key_map, column_drive, input ready);
  modport sink (input valid, key_map, column_drive, output ready);
endinterface

FILE: rtl/key_matrix_column_scanner.sv
// Four-column key matrix scanner: one poll tick in, one key map and drive level out.
//
//   channel  direction  contents
//   in_req   sink       row_lines, enter_pin, change_request, suspend
//   out_res  source     key_map, column_drive
//   cfg_*    write      idle_rescan_ticks (8 bits, reset 25)
//
// Each request is handled at acceptance: the scan state updates and the
// result lands in the output register on the same edge.
// A new request is taken every cycle while the output register is empty or
// being drained, so the throughput is one tick per clock.
// When the result is not taken, in_req.ready drops until it is.
// Reset (rst_n, synchronous) leaves no column driven, four columns pending
// and an empty key cache.
module key_matrix_column_scanner (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [kmcs_pkg::IDLE_W-1:0]  cfg_wdata,
  kmcs_in_if.sink                      in_req,
  kmcs_out_if.source                   out_res
);

  // Configuration: idle ticks before a forced rescan.
  logic [kmcs_pkg::IDLE_W-1:0] idle_thr_r;

  // Scan state.
  logic [kmcs_pkg::COL_W-1:0]   next_col_r,  next_col_nxt;
  logic [kmcs_pkg::COL_W-1:0]   samp_col_r,  samp_col_nxt;
  logic                         samp_vld_r,  samp_vld_nxt;
  logic [kmcs_pkg::PEND_W-1:0]  pend_r,      pend_nxt;
  logic [kmcs_pkg::IDLE_W-1:0]  idle_r,      idle_nxt;
  kmcs_pkg::col_keys_t          keys_r,      keys_nxt;
  logic [kmcs_pkg::COLUMNS-1:0] drive_r,     drive_nxt;

  // Output register.
  logic                           out_vld_r;
  logic [kmcs_pkg::KEY_MAP_W-1:0] out_map_r;
  logic [kmcs_pkg::COLUMNS-1:0]   out_drive_r;

  logic accept;

  // The output register frees up when it is empty or being read this cycle.
  assign in_req.ready = ~out_vld_r | out_res.ready;
  assign accept       = in_req.valid & in_req.ready;

  assign out_res.valid        = out_vld_r;
  assign out_res.key_map      = out_map_r;
  assign out_res.column_drive = out_drive_r;

  // Next scan state for one tick. A suspended tick leaves everything as it is.
  always_comb begin
    next_col_nxt = next_col_r;
    samp_col_nxt = samp_col_r;
    samp_vld_nxt = samp_vld_r;
    pend_nxt     = pend_r;
    idle_nxt     = idle_r;
    keys_nxt     = keys_r;
    drive_nxt    = drive_r;
    if (!in_req.suspend) begin
      // A change notice restarts a full pass over the columns.
      if (in_req.change_request) begin
        pend_nxt = kmcs_pkg::PEND_W'(kmcs_pkg::COLUMNS);
        idle_nxt = '0;
      end
      // With nothing pending, count idle ticks until a rescan is forced.
      if (pend_nxt == '0) begin
        idle_nxt = idle_nxt + 1'b1;
        if (idle_nxt >= idle_thr_r) begin
          pend_nxt = kmcs_pkg::PEND_W'(kmcs_pkg::COLUMNS);
          idle_nxt = '0;
        end
      end
      // Rows read now belong to the column driven on the previous tick.
      if (samp_vld_r && (pend_nxt != '0)) begin
        keys_nxt[samp_col_r] = ~in_req.row_lines;
        pend_nxt             = pend_nxt - 1'b1;
      end
      samp_col_nxt = next_col_r;
      samp_vld_nxt = 1'b1;
      drive_nxt    = ~(kmcs_pkg::COLUMNS'(1) << next_col_r);
      next_col_nxt = kmcs_pkg::COL_W'(next_col_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_thr_r <= kmcs_pkg::IDLE_RESCAN_RESET;
    end else if (cfg_we) begin
      idle_thr_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_col_r <= '0;
      samp_col_r <= '0;
      samp_vld_r <= 1'b0;
      pend_r     <= kmcs_pkg::PEND_W'(kmcs_pkg::COLUMNS);
      idle_r     <= '0;
      keys_r     <= '0;
      drive_r    <= '1;
    end else if (accept) begin
      next_col_r <= next_col_nxt;
      samp_col_r <= samp_col_nxt;
      samp_vld_r <= samp_vld_nxt;
      pend_r     <= pend_nxt;
      idle_r     <= idle_nxt;
      keys_r     <= keys_nxt;
      drive_r    <= drive_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (accept) begin
      out_vld_r <= 1'b1;
    end else if (out_res.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  // The key map is rebuilt from the updated cache so cached and fresh keys merge.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_map_r   <= kmcs_pkg::expand_keys(keys_nxt, in_req.enter_pin);
      out_drive_r <= drive_nxt;
    end
  end

  // Once a column has been driven, exactly one column line is low.
  a_one_col_low: assert property (@(posedge clk) disable iff (!rst_n)
    samp_vld_r |-> ($countones(~drive_r) == 1))
    else $error("column drive is not one-cold");

  // The pending count never exceeds a full pass.
  a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= kmcs_pkg::PEND_W'(kmcs_pkg::COLUMNS))
    else $error("pending column count out of range");

  // The sampled column is always the one just before the next column.
  a_col_order: assert property (@(posedge clk) disable iff (!rst_n)
    samp_vld_r |-> (next_col_r == kmcs_pkg::COL_W'(samp_col_r + 1'b1)))
    else $error("sample column and next column out of step");

  // A suspended tick changes no scan state.
  a_suspend_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req.suspend) |=>
      ($stable(pend_r) && $stable(next_col_r) && $stable(keys_r) && $stable(idle_r)))
    else $error("scan state moved on a suspended tick");

  // Every accepted request leaves a result waiting in the output register.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_vld_r)
    else $error("accepted request produced no result");

endmodule

FILE: tb/sv/scan_check.sv
// Checker for the key matrix scanner: predicts each tick's key map and column drive and compares.
module scan_check (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [kmcs_pkg::IDLE_W-1:0]  cfg_wdata,
  kmcs_in_if                           in_req,
  kmcs_out_if                          out_res,
  output int                           mismatches,
  output int                           results_owed
);

  typedef struct packed {
    logic [kmcs_pkg::KEY_MAP_W-1:0] key_map;
    logic [kmcs_pkg::COLUMNS-1:0]   column_drive;
  } scan_result_t;

  // Predicted scanner state.
  logic [kmcs_pkg::IDLE_W-1:0]  rescan_after;
  logic [kmcs_pkg::COL_W-1:0]   drive_col;
  logic [kmcs_pkg::COL_W-1:0]   sampled_col;
  logic                         sampled_ok;
  logic [kmcs_pkg::PEND_W-1:0]  cols_left;
  logic [kmcs_pkg::IDLE_W-1:0]  idle_count;
  logic [kmcs_pkg::ROWS-1:0]    cached [kmcs_pkg::COLUMNS];
  logic [kmcs_pkg::COLUMNS-1:0] drive;

  scan_result_t owed_q [$];
  int errors = 0;

  // Places the cached switches at their key map bits; enter is active low.
  function automatic logic [kmcs_pkg::KEY_MAP_W-1:0] key_map_of(input logic enter_n);
    logic [kmcs_pkg::KEY_MAP_W-1:0] map;
    map = '0;
    map[3]     = cached[0][0];
    map[2]     = cached[0][1];
    map[5]     = cached[0][2];
    map[4]     = cached[0][3];
    map[0]     = cached[1][0];
    map[1]     = cached[1][1];
    map[6]     = cached[1][2];
    map[7]     = cached[1][3];
    map[9]     = cached[2][0];
    map[8]     = cached[2][1];
    map[10]    = cached[2][2];
    map[11]    = cached[2][3];
    map[15:12] = cached[3];
    map[16]    = ~enter_n;
    return map;
  endfunction

  task automatic predict_tick(input logic [kmcs_pkg::ROWS-1:0] rows, input logic enter_n,
                              input logic change, input logic hold,
                              output scan_result_t res);
    if (!hold) begin
      if (change) begin
        cols_left  = kmcs_pkg::PEND_W'(kmcs_pkg::COLUMNS);
        idle_count = '0;
      end
      if (cols_left == 0) begin
        idle_count = idle_count + 1'b1;
        if (idle_count >= rescan_after) begin
          cols_left  = kmcs_pkg::PEND_W'(kmcs_pkg::COLUMNS);
          idle_count = '0;
        end
      end
      if (sampled_ok && cols_left != 0) begin
        cached[sampled_col] = ~rows;
        cols_left = cols_left - 1'b1;
      end
      sampled_col = drive_col;
      sampled_ok  = 1'b1;
      drive = '1;
      drive[drive_col] = 1'b0;
      drive_col = drive_col + 1'b1;
    end
    res.key_map      = key_map_of(enter_n);
    res.column_drive = drive;
  endtask

  always @(posedge clk) begin : watch
    scan_result_t got;
    scan_result_t want;
    scan_result_t fresh;
    if (!rst_n) begin
      rescan_after = kmcs_pkg::IDLE_RESCAN_RESET;
      drive_col    = '0;
      sampled_col  = '0;
      sampled_ok   = 1'b0;
      cols_left    = kmcs_pkg::PEND_W'(kmcs_pkg::COLUMNS);
      idle_count   = '0;
      drive        = '1;
      for (int c = 0; c < kmcs_pkg::COLUMNS; c++) cached[c] = '0;
      owed_q.delete();
    end else begin
      if (cfg_we) rescan_after = cfg_wdata;
      // A result leaving now belongs to a request taken on an earlier edge.
      if (out_res.valid && out_res.ready) begin
        got.key_map      = out_res.key_map;
        got.column_drive = out_res.column_drive;
        if (owed_q.size() == 0) begin
          $display("%0t: result with no request waiting: key_map %h column_drive %h",
                   $time, got.key_map, got.column_drive);
          errors++;
        end else begin
          want = owed_q.pop_front();
          if (got.key_map !== want.key_map) begin
            $display("%0t: key_map expected %h actual %h", $time, want.key_map,
                     got.key_map);
            errors++;
          end
          if (got.column_drive !== want.column_drive) begin
            $display("%0t: column_drive expected %h actual %h", $time,
                     want.column_drive, got.column_drive);
            errors++;
          end
        end
      end
      if (in_req.valid && in_req.ready) begin
        predict_tick(in_req.row_lines, in_req.enter_pin, in_req.change_request,
                     in_req.suspend, fresh);
        owed_q.push_back(fresh);
      end
    end
    mismatches   <= errors;
    results_owed <= owed_q.size();
  end

endmodule

FILE: tb/sv/testbench.sv
// Top of the scanner testbench: clock, reset, poll tick requests, threshold writes, verdict.
module testbench;

  // Chance in percent that a side idles on a given cycle.
  localparam int STALL_PCT      = 15;
  // Cycles with no request and no result taken before the run is declared hung.
  // Stalls are short random runs, so a correct block never comes near this.
  localparam int WATCHDOG_LIMIT = 2000;
  // Settle time after the last result; the block holds one result register.
  localparam int DRAIN_CYCLES   = 8;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  logic [kmcs_pkg::IDLE_W-1:0] cfg_wdata;
  logic                        quiet;
  int                          mismatches;
  int                          results_owed;
  int                          silent_cycles = 0;
  int                          ticks_sent = 0;
  int                          held_ticks = 0;
  int                          change_ticks = 0;
  int                          settings_used = 0;

  kmcs_in_if  in_req();
  kmcs_out_if out_res();

  key_matrix_column_scanner DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_req),
    .out_res   (out_res)
  );

  // The checker watches both channels and the register port on its own; this
  // module only makes stimulus and reads back the failure and backlog counts.
  scan_check u_scan_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_req       (in_req),
    .out_res      (out_res),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // The result side stalls at random unless a quiet stretch is running.
  always @(posedge clk) begin
    out_res.ready <= quiet || ($urandom_range(99) >= STALL_PCT);
  end

  // The watchdog ends the run if traffic stops on both channels for too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      silent_cycles <= 0;
    end else if ((in_req.valid && in_req.ready) || (out_res.valid && out_res.ready)) begin
      silent_cycles <= 0;
    end else if (silent_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      silent_cycles <= silent_cycles + 1;
    end
  end

  // Offers one poll tick, possibly after a few idle cycles, and returns at the
  // edge where it is accepted. The caller may then drive the next request at
  // that same edge, so valid stays high across back-to-back requests.
  task automatic send_tick(input logic [kmcs_pkg::ROWS-1:0] rows, input logic enter_n,
                           input logic change, input logic hold);
    while (!quiet && $urandom_range(99) < STALL_PCT) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid          <= 1'b1;
    in_req.row_lines      <= rows;
    in_req.enter_pin      <= enter_n;
    in_req.change_request <= change;
    in_req.suspend        <= hold;
    do @(posedge clk); while (!in_req.ready);
    ticks_sent++;
    if (hold) held_ticks++;
    if (change) change_ticks++;
  endtask

  // Random ticks with a given share of change requests and suspended ticks.
  // A low change share lets the pending count run out, so the idle counter
  // gets to climb toward the threshold and force rescans on its own.
  task automatic random_ticks(input int count, input int change_pct, input int hold_pct);
    for (int i = 0; i < count; i++) begin
      send_tick(kmcs_pkg::ROWS'($urandom_range(15)), 1'($urandom_range(1)),
                $urandom_range(99) < change_pct, $urandom_range(99) < hold_pct);
    end
  endtask

  // Writes the idle rescan threshold once the block has nothing in flight:
  // stop offering requests, wait for every owed result, then a short pause.
  task automatic set_threshold(input logic [kmcs_pkg::IDLE_W-1:0] value);
    in_req.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [kmcs_pkg::ROWS-1:0]   one_row;
    logic [kmcs_pkg::IDLE_W-1:0] mid_threshold;
    in_req.valid          <= 1'b0;
    in_req.row_lines      <= '1;
    in_req.enter_pin      <= 1'b1;
    in_req.change_request <= 1'b0;
    in_req.suspend        <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_wdata             <= '0;
    quiet                 <= 1'b0;
    rst_n                 <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, at the reset threshold of 25.
    // A suspended tick straight after reset must report only the enter key
    // and leave every column undriven.
    send_tick(4'h0, 1'b0, 1'b0, 1'b1);
    // The first live tick drives column 0 but has no driven column to sample.
    send_tick(4'h0, 1'b1, 1'b0, 1'b0);
    // Four ticks with every row pressed fill all four cached columns.
    repeat (4) send_tick(4'h0, 1'b1, 1'b0, 1'b0);
    // Suspended with enter pressed: full key map plus enter, drive held.
    send_tick(4'hF, 1'b0, 1'b0, 1'b1);
    // Nothing is pending now, so columns keep turning but the cache holds.
    repeat (3) send_tick(4'hF, 1'b1, 1'b0, 1'b0);
    // A change request starts a fresh pass that clears the released keys.
    send_tick(4'hF, 1'b1, 1'b1, 1'b0);
    // Single pressed rows, each with a change request so they are stored.
    for (int r = 0; r < kmcs_pkg::ROWS; r++) begin
      one_row    = '1;
      one_row[r] = 1'b0;
      send_tick(one_row, 1'b1, 1'b1, 1'b0);
    end
    send_tick(4'hA, 1'b0, 1'b1, 1'b0);
    send_tick(4'h5, 1'b1, 1'b0, 1'b0);
    // A change request while suspended must be ignored entirely.
    send_tick(4'h3, 1'b0, 1'b1, 1'b1);

    // Lowest threshold: every idle tick forces a rescan at once.
    set_threshold(8'd1);
    random_ticks(80, 10, 10);
    // Highest threshold with no change requests, long enough for the idle
    // counter to climb all the way up and force a rescan.
    set_threshold(8'd255);
    random_ticks(280, 0, 5);
    // A quiet stretch: neither side idles, requests go through back to back.
    quiet <= 1'b1;
    mid_threshold = kmcs_pkg::IDLE_W'($urandom_range(254, 2));
    set_threshold(mid_threshold);
    random_ticks(100, 20, 15);
    quiet <= 1'b0;
    set_threshold(8'd3);
    random_ticks(70, 5, 20);

    in_req.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d poll ticks: %0d suspended, %0d carrying a change request.",
             ticks_sent, held_ticks, change_ticks);
    $display("Idle thresholds: reset 25, then %0d writes of 1, 255, %0d and 3.",
             settings_used, mid_threshold);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
